[design/bmblur_pkg.sv]
// ----------------------------------------------------------------------------
// bmblur_pkg: shared definitions for the 3x3 binomial mask blur
// Register indexes, field widths and line buffer lane helpers.
// ----------------------------------------------------------------------------
package bmblur_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int BLUR_W      = 5;
    localparam int COORD_W     = 8;
    localparam int LANE_W      = 8;
    localparam int NUM_LANES   = 3;
    // Window of columns base-2 .. base+8 around one packed byte.
    localparam int WIN_W       = 11;

    localparam logic [CFG_DATA_W-1:0] CFG_DIM_RESET = 9'd256;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MASK_WIDTH  = 2'd0,
        CFG_MASK_HEIGHT = 2'd1
    } cfg_index_t;

    typedef logic [1:0]       lane_t;
    typedef logic [WIN_W-1:0] win_t;

    // The lower line sits in lane p, the middle line in the lane before it and
    // the upper line in the lane after it. Rotating p moves every line up one.
    function automatic lane_t lane_up(lane_t p);
        lane_t r;
        case (p)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic lane_t lane_mid(lane_t p);
        lane_t r;
        case (p)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd0;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    function automatic logic [LANE_W-1:0] lane_of(logic [NUM_LANES*LANE_W-1:0] word,
                                                  lane_t l);
        logic [LANE_W-1:0] r;
        case (l)
            2'd0:    r = word[LANE_W-1:0];
            2'd1:    r = word[2*LANE_W-1:LANE_W];
            default: r = word[3*LANE_W-1:2*LANE_W];
        endcase
        return r;
    endfunction

endpackage

[design/bitmask_binomial_blur_3x3_core.sv]
// ----------------------------------------------------------------------------
// bitmask_binomial_blur_3x3_core: 3x3 binomial blur of a packed 1-bit mask
//
// Configuration: cfg_valid/cfg_ready write mask_width (index 0) or mask_height
// (index 1); cfg_ready is always high and either write restarts the frame.
// Input: in_valid/in_ready carry mode and mask_byte. Mode 0 transfers eight
// pixels of the current row, LSB first; mode 1 is a drain step that releases
// up to eight pixels of the last row once all rows have arrived.
// Output: out_valid/out_ready carry one blurred pixel per transfer, with
// last_of_run on the final pixel of an input transfer and frame_end on the
// last pixel of the frame.
// A transfer passes the read stage, the emit stage and the result register.
// Throughput: one result per cycle while out_ready is high; an input transfer
// yielding n results (up to nine) occupies the emit stage until its last
// result is loaded. The single result register sets this rate.
// The three line buffers share one memory word per byte column, one lane per
// line; a row end rotates the lanes instead of copying lines.
// Reset returns the frame counters to zero and both dimensions to 256; line
// contents are not cleared. When the receiver stalls, the result holds and up
// to two more transfers that yield results are taken before in_ready drops.
// ----------------------------------------------------------------------------
module bitmask_binomial_blur_3x3_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bmblur_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bmblur_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               mode,
    input  logic [7:0]                         mask_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [bmblur_pkg::BLUR_W-1:0]      blur_sixteenths,
    output logic [bmblur_pkg::COORD_W-1:0]     pixel_x,
    output logic [bmblur_pkg::COORD_W-1:0]     pixel_y,
    output logic                               last_of_run,
    output logic                               frame_end
);
    import bmblur_pkg::*;

    localparam int WORDS = (MAX_WIDTH + 7) / 8;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int XW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int SW    = XW + 4;
    localparam logic [3:0] E_FIRST = 4'd2;

    // Configuration and frame counters.
    logic [CFG_DATA_W-1:0] cfg_w_reg, cfg_h_reg;
    logic [XW-1:0]         eff_w;
    logic [HW-1:0]         eff_h;
    logic [AW-1:0]         col_reg, col_next;
    logic [HW-1:0]         row_reg, row_next;
    logic [AW-1:0]         drain_reg, drain_next;
    logic                  done_reg, done_next;
    lane_t                 bank_reg, bank_next;

    // Line buffer memory.
    logic [NUM_LANES*LANE_W-1:0] mem [WORDS];
    logic [NUM_LANES*LANE_W-1:0] rd_a_reg, rd_b_reg;

    // Read stage.
    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_drain_reg, s1_above_mid_reg, s1_final_reg;
    logic [LANE_W-1:0]     s1_byte_reg;
    lane_t                 s1_bank_reg;
    logic [XW-1:0]         s1_xs_reg, s1_xe_reg;
    logic [3:0]            s1_e_reg;
    logic [HW-1:0]         s1_y_reg;

    // Emit stage.
    logic                  job_valid_reg, job_valid_next;
    logic [XW-1:0]         job_x_reg, job_xe_reg;
    logic [3:0]            job_e_reg;
    logic [HW-1:0]         job_y_reg;
    logic                  job_final_reg;
    win_t                  job_a_reg, job_m_reg, job_b_reg;
    logic [1:0]            cy_a_reg, cy_m_reg, cy_b_reg;

    // Result register.
    logic                  out_valid_reg, out_valid_next;
    logic [BLUR_W-1:0]     out_blur_reg;
    logic [COORD_W-1:0]    out_x_reg, out_y_reg;
    logic                  out_last_reg, out_fend_reg;

    // Handshakes and accept-side decode.
    logic                  cfg_fire, cfg_restart, in_fire, byte_go, drain_go, s1_load;
    logic                  s1_adv, job_free, job_last, out_load;
    logic [AW-1:0]         acc_word, acc_next_word;
    logic [XW-1:0]         base_col, acc_xs, acc_xe;
    logic                  row_end;

    // Window build.
    logic [LANE_W-1:0]     up_cur, mid_cur, up_nxt_w, mid_nxt_w;
    logic [LANE_W-1:0]     above_cur, below_cur;
    logic                  above_nxt, below_nxt;

    // Blur arithmetic.
    logic [3:0]            idx_l, idx_r;
    logic [2:0]            sum_a, sum_m, sum_b;
    logic [BLUR_W-1:0]     blur_val;

    function automatic logic [2:0] tap_sum(win_t w, logic [3:0] l, logic [3:0] c,
                                           logic [3:0] r);
        return 3'(w[l]) + {1'b0, w[c], 1'b0} + 3'(w[r]);
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_restart = cfg_fire &&
                         (cfg_index_t'(cfg_index) == CFG_MASK_WIDTH ||
                          cfg_index_t'(cfg_index) == CFG_MASK_HEIGHT);

    always_comb
    begin
        if (cfg_w_reg == '0)
            eff_w = XW'(1);
        else if (32'(cfg_w_reg) > 32'(MAX_WIDTH))
            eff_w = XW'(MAX_WIDTH);
        else
            eff_w = XW'(cfg_w_reg);
        if (cfg_h_reg == '0)
            eff_h = HW'(1);
        else if (32'(cfg_h_reg) > 32'(MAX_HEIGHT))
            eff_h = HW'(MAX_HEIGHT);
        else
            eff_h = HW'(cfg_h_reg);
    end

    assign in_fire  = in_valid && in_ready;
    assign byte_go  = in_fire && !mode && !done_reg;
    assign drain_go = in_fire && mode && done_reg;
    // Row-0 bytes only fill the buffer; ignored items never reach the pipe.
    assign s1_load  = (byte_go && row_reg != '0) || drain_go;

    assign acc_word      = mode ? drain_reg : col_reg;
    assign acc_next_word = (acc_word == AW'(WORDS - 1)) ? acc_word : acc_word + AW'(1);
    assign base_col      = XW'({acc_word, 3'b000});
    // True on the last byte of a row and on the final drain step.
    assign row_end       = (SW'(base_col) + SW'(8)) >= SW'(eff_w);

    always_comb
    begin
        if (mode)
            acc_xs = base_col;
        else if (base_col == '0)
            acc_xs = '0;
        else
            acc_xs = base_col - XW'(1);
        if (row_end)
            acc_xe = eff_w - XW'(1);
        else
            acc_xe = base_col + (mode ? XW'(7) : XW'(6));
    end

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        done_next  = done_reg;
        bank_next  = bank_reg;
        if (cfg_restart)
        begin
            col_next   = '0;
            row_next   = '0;
            drain_next = '0;
            done_next  = 1'b0;
        end
        else if (byte_go)
        begin
            if (row_end)
            begin
                col_next  = '0;
                bank_next = lane_up(bank_reg);
                row_next  = row_reg + HW'(1);
                if ((row_reg + HW'(1)) >= eff_h)
                    done_next = 1'b1;
            end
            else
            begin
                col_next = col_reg + AW'(1);
            end
        end
        else if (drain_go)
        begin
            if (row_end)
            begin
                col_next   = '0;
                row_next   = '0;
                drain_next = '0;
                done_next  = 1'b0;
            end
            else
            begin
                drain_next = drain_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg <= CFG_DIM_RESET;
            cfg_h_reg <= CFG_DIM_RESET;
            col_reg   <= '0;
            row_reg   <= '0;
            drain_reg <= '0;
            done_reg  <= 1'b0;
            bank_reg  <= '0;
        end
        else
        begin
            if (cfg_fire && cfg_index_t'(cfg_index) == CFG_MASK_WIDTH)
                cfg_w_reg <= cfg_data;
            if (cfg_fire && cfg_index_t'(cfg_index) == CFG_MASK_HEIGHT)
                cfg_h_reg <= cfg_data;
            col_reg   <= col_next;
            row_reg   <= row_next;
            drain_reg <= drain_next;
            done_reg  <= done_next;
            bank_reg  <= bank_next;
        end
    end

    // The incoming byte goes straight into the lower lane. The read at the same
    // edge returns the old word, whose lower lane is not used for that byte.
    always_ff @(posedge clk)
    begin
        if (byte_go)
            mem[col_reg][LANE_W*bank_reg +: LANE_W] <= mask_byte;
        if (s1_load)
        begin
            rd_a_reg <= mem[acc_word];
            rd_b_reg <= mem[acc_next_word];
        end
    end

    assign job_last = job_x_reg == job_xe_reg;
    assign out_load = job_valid_reg && (!out_valid_reg || out_ready);
    assign job_free = !job_valid_reg || (out_load && job_last);
    assign s1_adv   = s1_valid_reg && job_free;
    assign in_ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_drain_reg     <= mode;
            s1_byte_reg      <= mask_byte;
            s1_bank_reg      <= bank_reg;
            s1_xs_reg        <= acc_xs;
            s1_xe_reg        <= acc_xe;
            s1_e_reg         <= (mode || base_col == '0) ? E_FIRST : E_FIRST - 4'd1;
            s1_y_reg         <= mode ? eff_h - HW'(1) : row_reg - HW'(1);
            s1_above_mid_reg <= mode ? (eff_h == HW'(1)) : (row_reg == HW'(1));
            s1_final_reg     <= mode && row_end;
        end
    end

    // Above, middle and below rows for the word just read.
    assign up_cur    = lane_of(rd_a_reg, lane_up(s1_bank_reg));
    assign mid_cur   = lane_of(rd_a_reg, lane_mid(s1_bank_reg));
    assign up_nxt_w  = lane_of(rd_b_reg, lane_up(s1_bank_reg));
    assign mid_nxt_w = lane_of(rd_b_reg, lane_mid(s1_bank_reg));
    assign above_cur = s1_above_mid_reg ? mid_cur : up_cur;
    assign above_nxt = s1_above_mid_reg ? mid_nxt_w[0] : up_nxt_w[0];
    assign below_cur = s1_drain_reg ? mid_cur : s1_byte_reg;
    assign below_nxt = s1_drain_reg ? mid_nxt_w[0] : 1'b0;

    always_comb
    begin
        job_valid_next = job_valid_reg;
        if (s1_adv)
            job_valid_next = 1'b1;
        else if (out_load && job_last)
            job_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            job_x_reg     <= s1_xs_reg;
            job_xe_reg    <= s1_xe_reg;
            job_e_reg     <= s1_e_reg;
            job_y_reg     <= s1_y_reg;
            job_final_reg <= s1_final_reg;
            job_a_reg     <= {above_nxt, above_cur, cy_a_reg};
            job_m_reg     <= {mid_nxt_w[0], mid_cur, cy_m_reg};
            job_b_reg     <= {below_nxt, below_cur, cy_b_reg};
            cy_a_reg      <= above_cur[LANE_W-1:LANE_W-2];
            cy_m_reg      <= mid_cur[LANE_W-1:LANE_W-2];
            cy_b_reg      <= below_cur[LANE_W-1:LANE_W-2];
        end
        else if (out_load)
        begin
            job_x_reg <= job_x_reg + XW'(1);
            job_e_reg <= job_e_reg + 4'd1;
        end
    end

    // Replicate border: a missing neighbor column is the pixel's own column.
    assign idx_l    = (job_x_reg == '0) ? job_e_reg : job_e_reg - 4'd1;
    assign idx_r    = (job_x_reg == eff_w - XW'(1)) ? job_e_reg : job_e_reg + 4'd1;
    assign sum_a    = tap_sum(job_a_reg, idx_l, job_e_reg, idx_r);
    assign sum_m    = tap_sum(job_m_reg, idx_l, job_e_reg, idx_r);
    assign sum_b    = tap_sum(job_b_reg, idx_l, job_e_reg, idx_r);
    assign blur_val = BLUR_W'(sum_a) + {1'b0, sum_m, 1'b0} + BLUR_W'(sum_b);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_blur_reg <= blur_val;
            out_x_reg    <= COORD_W'(job_x_reg);
            out_y_reg    <= COORD_W'(job_y_reg);
            out_last_reg <= job_last;
            out_fend_reg <= job_last && job_final_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            job_valid_reg <= job_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign blur_sixteenths = out_blur_reg;
    assign pixel_x         = out_x_reg;
    assign pixel_y         = out_y_reg;
    assign last_of_run     = out_last_reg;
    assign frame_end       = out_fend_reg;

endmodule

[design/bmblur_checker.sv]
// ----------------------------------------------------------------------------
// bmblur_checker: result channel checks for the 3x3 mask blur
// Watches the result ports only and is bound to the top level.
// ----------------------------------------------------------------------------
module bmblur_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [bmblur_pkg::BLUR_W-1:0]  blur_sixteenths,
    input logic [bmblur_pkg::COORD_W-1:0] pixel_x,
    input logic [bmblur_pkg::COORD_W-1:0] pixel_y,
    input logic                           last_of_run,
    input logic                           frame_end
);
    import bmblur_pkg::*;

    localparam logic [BLUR_W-1:0] BLUR_MAX = 5'd16;

    // A stalled result keeps its whole payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(blur_sixteenths) &&
        $stable(pixel_x) && $stable(pixel_y) && $stable(last_of_run) &&
        $stable(frame_end))
        else $error("result changed while stalled");

    // The weights sum to sixteen, so no result can exceed it.
    a_blur_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> blur_sixteenths <= BLUR_MAX)
        else $error("blurred value out of range");

    a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> last_of_run)
        else $error("frame end not on the last result of a run");

    // Within a run the pixels follow each other along one row without a gap.
    a_run_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=>
        out_valid && pixel_y == $past(pixel_y) &&
        pixel_x == $past(pixel_x) + COORD_W'(1))
        else $error("run did not continue with the next column");

endmodule

bind bitmask_binomial_blur_3x3_core bmblur_checker u_bmblur_checker (.*);

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for bitmask_binomial_blur_3x3_core
// Streams packed mask frames of many sizes through the blur core with random
// idle cycles on both sides, predicts every blurred pixel in a scoreboard and
// compares each result transfer against the oldest predicted pixel.
// ----------------------------------------------------------------------------
module tb;

    import bmblur_pkg::*;

    localparam int SETTLE_CYCLES = 6;
    localparam int MASK_ITEMS    = 170;

    typedef struct packed {
        logic [BLUR_W-1:0]  sixteenths;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last_run;
        logic               frame_end;
    } blur_pixel_t;

    class blur_scoreboard;
        bit [CFG_DATA_W-1:0] width_reg;
        bit [CFG_DATA_W-1:0] height_reg;
        bit [255:0]          upper_row;
        bit [255:0]          middle_row;
        bit [255:0]          lower_row;
        int unsigned         byte_col;
        int unsigned         row_idx;
        int unsigned         drain_col;
        bit                  rows_complete;
        blur_pixel_t         expected_pixels[$];
        int unsigned         mismatches;

        function new();
            width_reg  = CFG_DIM_RESET;
            height_reg = CFG_DIM_RESET;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            byte_col      = 0;
            row_idx       = 0;
            drain_col     = 0;
            rows_complete = 1'b0;
        endfunction

        function int unsigned clamp_dim(bit [CFG_DATA_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > 256)
                return 256;
            return 32'(v);
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_MASK_WIDTH)
            begin
                width_reg = data;
                restart();
            end
            else if (idx == CFG_MASK_HEIGHT)
            begin
                height_reg = data;
                restart();
            end
        endfunction

        // Horizontal 1-2-1 tap with the column clamped into the row.
        function int unsigned weighted_row(bit [255:0] line, int unsigned x, int unsigned w);
            int unsigned xl;
            int unsigned xr;
            xl = (x > 0) ? x - 1 : 0;
            xr = (x + 1 < w) ? x + 1 : w - 1;
            return 32'(line[xl]) + 2 * 32'(line[x]) + 32'(line[xr]);
        endfunction

        function void add_pixel(int unsigned x, int unsigned y, bit [255:0] above,
                                bit [255:0] mid, bit [255:0] below, int unsigned w);
            blur_pixel_t p;
            int unsigned s;
            s = weighted_row(above, x, w) + 2 * weighted_row(mid, x, w)
                + weighted_row(below, x, w);
            p.sixteenths = s[BLUR_W-1:0];
            p.x          = x[COORD_W-1:0];
            p.y          = y[COORD_W-1:0];
            p.last_run   = 1'b0;
            p.frame_end  = 1'b0;
            expected_pixels.insert(expected_pixels.size(), p);
        endfunction

        function void note_mask_item(logic drain, logic [7:0] bits);
            int unsigned w;
            int unsigned h;
            int unsigned pitch;
            int unsigned c;
            int unsigned y;
            int unsigned i;
            int unsigned first;
            bit [255:0]  above;
            blur_pixel_t tail;
            w     = clamp_dim(width_reg);
            h     = clamp_dim(height_reg);
            first = expected_pixels.size();
            if (!drain)
            begin
                if (rows_complete)
                    return;
                pitch = (w + 7) / 8;
                for (i = 0; i < 8; i++)
                begin
                    c = byte_col * 8 + i;
                    if (c >= w)
                        break;
                    lower_row[c] = bits[i];
                    // A pixel of row y is complete once its lower right neighbor in row y+1 is in.
                    if (row_idx >= 1)
                    begin
                        y     = row_idx - 1;
                        above = (y == 0) ? middle_row : upper_row;
                        if (c >= 1)
                            add_pixel(c - 1, y, above, middle_row, lower_row, w);
                        if (c == w - 1)
                            add_pixel(w - 1, y, above, middle_row, lower_row, w);
                    end
                end
                byte_col++;
                if (byte_col >= pitch)
                begin
                    byte_col   = 0;
                    upper_row  = middle_row;
                    middle_row = lower_row;
                    row_idx++;
                    if (row_idx >= h)
                        rows_complete = 1'b1;
                end
            end
            else
            begin
                if (!rows_complete)
                    return;
                y     = h - 1;
                above = (y == 0) ? middle_row : upper_row;
                for (i = 0; i < 8 && drain_col < w; i++)
                begin
                    add_pixel(drain_col, y, above, middle_row, middle_row, w);
                    drain_col++;
                end
                if (drain_col >= w)
                begin
                    tail           = expected_pixels[expected_pixels.size() - 1];
                    tail.frame_end = 1'b1;
                    expected_pixels[expected_pixels.size() - 1] = tail;
                    restart();
                end
            end
            if (expected_pixels.size() > first)
            begin
                tail          = expected_pixels[expected_pixels.size() - 1];
                tail.last_run = 1'b1;
                expected_pixels[expected_pixels.size() - 1] = tail;
            end
        endfunction

        function void check_pixel(blur_pixel_t got);
            blur_pixel_t want;
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: v=%0d x=%0d y=%0d last=%0b end=%0b",
                             got.sixteenths, got.x, got.y, got.last_run, got.frame_end);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.sixteenths !== want.sixteenths || got.x !== want.x || got.y !== want.y
                || got.last_run !== want.last_run || got.frame_end !== want.frame_end)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected v=%0d x=%0d y=%0d last=%0b end=%0b",
                             want.sixteenths, want.x, want.y, want.last_run,
                             want.frame_end,
                             ", got v=%0d x=%0d y=%0d last=%0b end=%0b",
                             got.sixteenths, got.x, got.y, got.last_run, got.frame_end);
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_MASK_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   mode = 1'b0;
    logic [7:0]             mask_byte = 8'h00;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [BLUR_W-1:0]      blur_sixteenths;
    logic [COORD_W-1:0]     pixel_x;
    logic [COORD_W-1:0]     pixel_y;
    logic                   last_of_run;
    logic                   frame_end;

    blur_scoreboard sb = new();
    bit             calm = 1'b0;
    bit [CFG_DATA_W-1:0] cur_w = CFG_DIM_RESET;
    bit [CFG_DATA_W-1:0] cur_h = CFG_DIM_RESET;

    bitmask_binomial_blur_3x3_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .mask_byte       (mask_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .blur_sixteenths (blur_sixteenths),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .last_of_run     (last_of_run),
        .frame_end       (frame_end)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_register(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_mask_item(mode, mask_byte);
            if (out_valid && out_ready)
                sb.check_pixel('{blur_sixteenths, pixel_x, pixel_y, last_of_run, frame_end});
        end
    end

    function automatic int draw_idle();
        if (calm)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [7:0] draw_mask_bits();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Valid stays high across back-to-back transfers; it only drops for a gap.
    task automatic send_item(input logic drain, input logic [7:0] bits);
        int gap;
        gap = draw_idle();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= drain;
        mask_byte <= bits;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.expected_pixels.size() != 0);
        // A transfer that yields no pixel may still be inside the core.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_dims(input bit wr_w, input bit [CFG_DATA_W-1:0] w_val,
                            input bit wr_h, input bit [CFG_DATA_W-1:0] h_val);
        if (wr_w)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_MASK_WIDTH;
            cfg_data  <= w_val;
            cur_w     = w_val;
            do @(posedge clk); while (!cfg_ready);
        end
        if (wr_h)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_MASK_HEIGHT;
            cfg_data  <= h_val;
            cur_h     = h_val;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned         stalls;
        wait (rst_n === 1'b1);
        forever
        begin
            stalls = draw_idle();
            if (stalls > 0)
            begin
                out_ready <= 1'b0;
                repeat (stalls) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        int unsigned         placed;
        int unsigned         w;
        int unsigned         h;
        int unsigned         pitch;
        int unsigned         rows;
        int unsigned         sel;
        int unsigned         which;
        bit                  must_cfg;
        bit [CFG_DATA_W-1:0] nw;
        bit [CFG_DATA_W-1:0] nh;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Partial frame at the reset size, then a drain before the rows are in.
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h00);
        send_item(1'b1, 8'h00);
        wait_drained();

        // Zero dimensions saturate to a single pixel; padding bits are set.
        set_dims(1'b1, 9'd0, 1'b1, 9'd0);
        send_item(1'b0, 8'hFE);
        send_item(1'b0, 8'hFF);
        send_item(1'b1, 8'hA5);
        send_item(1'b1, 8'h5A);
        wait_drained();

        // Nine columns: seven padding bits in every second byte.
        set_dims(1'b1, 9'd9, 1'b1, 9'd3);
        send_item(1'b0, 8'hAA);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h55);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h01);
        send_item(1'b1, 8'h00);
        send_item(1'b1, 8'hFF);
        wait_drained();

        set_dims(1'b1, 9'd8, 1'b1, 9'd2);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b1, 8'h00);

        placed   = 0;
        must_cfg = 1'b1;
        while (placed < MASK_ITEMS)
        begin
            calm = ($urandom_range(0, 4) == 0);
            if (must_cfg || $urandom_range(0, 2) != 0)
            begin
                sel = (placed == 0) ? 0 : $urandom_range(0, 9);
                if (sel == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       nw = 9'd0;
                        1:       nw = 9'd255;
                        2:       nw = 9'd256;
                        default: nw = 9'd511;
                    endcase
                    if (placed == 0)
                        nw = 9'd511;
                    nh = 9'($urandom_range(0, 1));
                end
                else if (sel == 1)
                begin
                    nw = 9'($urandom_range(1, 12));
                    case ($urandom_range(0, 2))
                        0:       nh = 9'd256;
                        1:       nh = 9'd300;
                        default: nh = 9'd511;
                    endcase
                end
                else
                begin
                    nw = 9'($urandom_range(1, 24));
                    nh = 9'($urandom_range(1, 5));
                end
                which = (placed == 0) ? 0 : $urandom_range(0, 3);
                wait_drained();
                set_dims(which != 2, nw, which != 1, nh);
                must_cfg = 1'b0;
            end

            w     = sb.clamp_dim(cur_w);
            h     = sb.clamp_dim(cur_h);
            pitch = (w + 7) / 8;
            rows  = h;
            if (h > 6)
                rows = $urandom_range(1, 4);
            else if ($urandom_range(0, 7) == 0)
                rows = $urandom_range(0, h - 1);

            for (int r = 0; r < rows; r++)
            begin
                for (int k = 0; k < pitch; k++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_item(1'b1, 8'($urandom_range(0, 255)));
                    send_item(1'b0, draw_mask_bits());
                    placed++;
                    if ($urandom_range(0, 49) == 0)
                        wait_drained();
                end
            end

            // An unfinished frame can only be abandoned through a register write.
            if (rows < h)
                must_cfg = 1'b1;
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 2)) send_item(1'b0, 8'($urandom_range(0, 255)));
                for (int k = 0; k < pitch; k++)
                begin
                    send_item(1'b1, 8'($urandom_range(0, 255)));
                    placed++;
                end
            end
        end

        calm = 1'b0;
        wait_drained();
        if (sb.mismatches == 0)
            $display("PASS bitmask_binomial_blur_3x3_core");
        else
            $display("FAIL bitmask_binomial_blur_3x3_core");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL bitmask_binomial_blur_3x3_core");
        $finish;
    end

endmodule
